FILE: design/sht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_pkg - shared types and constants of the scheduled thermostat
// widths, register indexes, slot layout and small helper functions
// ----------------------------------------------------------------------------
package sht_pkg;

    // stream and configuration widths
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 56;

    // slot layout inside a 28-bit slot
    localparam int SLOT_W        = 28;
    localparam int SLOT_EN_BIT   = 27;
    localparam int SLOTS_PER_DAY = 4;
    localparam int SLOT_REGS     = 4;

    // time of day in minutes, up to 31*60+63
    localparam int MINS_W = 11;

    // manual setpoint clamp limits, tenths of a degree
    localparam logic signed [11:0] SP_MIN = 12'sd50;
    localparam logic signed [11:0] SP_MAX = 12'sd350;

    // reset values
    localparam logic signed [11:0] SETPOINT_RST   = 12'sd200;
    localparam logic [7:0]         HYSTERESIS_RST = 8'd10;
    localparam logic [5:0]         NO_MINUTE      = 6'd63;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HYSTERESIS   = 3'd0,
        REG_SCHED_ENABLE = 3'd1,
        REG_WEEKDAY_LO   = 3'd2,
        REG_WEEKDAY_HI   = 3'd3,
        REG_WEEKEND_LO   = 3'd4,
        REG_WEEKEND_HI   = 3'd5
    } reg_index_t;

    // configuration state seen by the datapath
    typedef struct packed {
        logic [7:0]                            hysteresis;
        logic                                  sched_on;
        logic [SLOT_REGS-1:0][CFG_DATA_W-1:0]  slot_regs;
    } cfg_t;

    // outcome of the slot search
    typedef struct packed {
        logic               found;
        logic signed [11:0] setpoint;
    } sched_t;

    // hour and minute to minutes of the day, taken as given
    function automatic logic [MINS_W-1:0] day_minutes(input logic [4:0] hour,
                                                      input logic [5:0] minute);
        logic [MINS_W-1:0] hour_mins;
        hour_mins = MINS_W'({hour, 6'b0}) - MINS_W'({hour, 2'b0});
        return hour_mins + MINS_W'(minute);
    endfunction

    // saturate a 16-bit signed slot setpoint into 12 bits
    function automatic logic signed [11:0] sat12(input logic signed [15:0] v);
        logic signed [11:0] r;
        if (v > 16'sd2047) begin
            r = 12'sd2047;
        end else if (v < -16'sd2048) begin
            r = -12'sd2048;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

FILE: design/sht_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_cfg_regs - configuration register file
// hysteresis, schedule enable and the four packed slot registers
// ----------------------------------------------------------------------------
module sht_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sht_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sht_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sht_pkg::cfg_t                      cfg
);

    sht_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hysteresis   <= sht_pkg::HYSTERESIS_RST;
            cfg_reg.sched_on     <= 1'b0;
            cfg_reg.slot_regs    <= '0;
        end else if (cfg_valid) begin
            unique case (sht_pkg::reg_index_t'(cfg_index))
                sht_pkg::REG_HYSTERESIS:   cfg_reg.hysteresis   <= cfg_data[7:0];
                sht_pkg::REG_SCHED_ENABLE: cfg_reg.sched_on     <= cfg_data[0];
                sht_pkg::REG_WEEKDAY_LO:   cfg_reg.slot_regs[0] <= cfg_data;
                sht_pkg::REG_WEEKDAY_HI:   cfg_reg.slot_regs[1] <= cfg_data;
                sht_pkg::REG_WEEKEND_LO:   cfg_reg.slot_regs[2] <= cfg_data;
                sht_pkg::REG_WEEKEND_HI:   cfg_reg.slot_regs[3] <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/sht_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_sched - schedule slot search
// finds the latest enabled slot of the day's set at or before now
// ----------------------------------------------------------------------------
module sht_sched (
    input  sht_pkg::cfg_t    cfg,
    input  logic [4:0]       hour,
    input  logic [5:0]       minute,
    input  logic [2:0]       weekday,
    output sht_pkg::sched_t  sched
);

    logic                                weekend;
    logic [sht_pkg::MINS_W-1:0]          now_mins;
    logic [sht_pkg::SLOT_W-1:0]          slot [sht_pkg::SLOTS_PER_DAY];
    logic [sht_pkg::MINS_W-1:0]          slot_time [sht_pkg::SLOTS_PER_DAY];

    // monday..friday use the weekday set, anything else the weekend set
    assign weekend  = !((weekday >= 3'd2) && (weekday <= 3'd6));
    assign now_mins = sht_pkg::day_minutes(hour, minute);

    always_comb begin
        logic [sht_pkg::CFG_DATA_W-1:0] r;
        for (int i = 0; i < sht_pkg::SLOTS_PER_DAY; i++) begin
            r = cfg.slot_regs[{weekend, 1'(i >> 1)}];
            slot[i] = (i % 2 == 1) ? r[2*sht_pkg::SLOT_W-1:sht_pkg::SLOT_W]
                                   : r[sht_pkg::SLOT_W-1:0];
            slot_time[i] = sht_pkg::day_minutes(slot[i][26:22], slot[i][21:16]);
        end
    end

    // later slots win ties
    always_comb begin
        logic [sht_pkg::MINS_W-1:0] best_mins;
        logic [15:0]                best_sp;
        logic                       found;
        best_mins = '0;
        best_sp   = '0;
        found     = 1'b0;
        for (int i = 0; i < sht_pkg::SLOTS_PER_DAY; i++) begin
            if (slot[i][sht_pkg::SLOT_EN_BIT] && (slot_time[i] <= now_mins) &&
                (slot_time[i] >= best_mins)) begin
                best_mins = slot_time[i];
                best_sp   = slot[i][15:0];
                found     = 1'b1;
            end
        end
        sched.found    = found;
        sched.setpoint = sht_pkg::sat12($signed(best_sp));
    end

endmodule

FILE: design/scheduled_hysteresis_thermostat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat - heat/cool thermostat with time schedule
// hysteresis relay control plus weekday/weekend setpoint schedule
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            content
//  s_        in         s_tvalid/s_tready    tick or manual word
//  m_        out        m_tvalid/m_tready    relay, setpoint, override word
//  cfg_      in         cfg_valid/cfg_ready  register index and write data
//
//  one word per cycle sustained while m_tready stays high; a result word is
//  offered once its word has passed the input and then the result register
//  the rate is set by the single pass from input register to result register
//  reset (aresetn low, synchronous) empties both registers and restores state
//  a stalled result holds; the input register still drains into it when
//  m_tready is high in the same cycle, so s_tready stays high under flow
//
module scheduled_hysteresis_thermostat (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] temperature, [16:12] hour, [22:17] minute, [25:23] weekday,
    // [37:26] manual_setpoint, [39:38] zero
    input  logic [sht_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] func
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] heating_on, [1] cooling_on, [13:2] setpoint_now,
    // [14] override_active, [15] zero
    output logic [sht_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sht_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sht_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    sht_pkg::cfg_t   cfg;
    sht_pkg::sched_t sched;

    // input register
    logic                                in_valid_reg;
    logic                                in_func_reg;
    logic [sht_pkg::IN_DATA_W-1:0]       in_data_reg;

    // thermostat state
    logic signed [11:0] setpoint_reg,     setpoint_next;
    logic               override_reg,     override_next;
    logic [5:0]         seen_minute_reg,  seen_minute_next;
    logic               heat_reg,         heat_next;
    logic               cool_reg,         cool_next;

    // result register
    logic                                out_valid_reg;
    logic [sht_pkg::OUT_DATA_W-1:0]      out_data_reg;

    // unpacked fields of the held word
    logic signed [11:0] temperature;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [2:0]         weekday;
    logic signed [11:0] manual_sp;

    logic               fire;
    logic signed [13:0] temp_ext;
    logic signed [13:0] band_lo;
    logic signed [13:0] band_hi;

    sht_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign temperature = in_data_reg[11:0];
    assign hour        = in_data_reg[16:12];
    assign minute      = in_data_reg[22:17];
    assign weekday     = in_data_reg[25:23];
    assign manual_sp   = in_data_reg[37:26];

    sht_sched u_sched (
        .cfg     (cfg),
        .hour    (hour),
        .minute  (minute),
        .weekday (weekday),
        .sched   (sched)
    );

    // the held word moves on when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // band edges are setpoint -/+ hysteresis/2, truncated
    assign temp_ext = {{2{temperature[11]}}, temperature};
    assign band_lo  = $signed({{2{setpoint_reg[11]}}, setpoint_reg})
                    - $signed({7'b0, cfg.hysteresis[7:1]});
    assign band_hi  = $signed({{2{setpoint_reg[11]}}, setpoint_reg})
                    + $signed({7'b0, cfg.hysteresis[7:1]});

    always_comb begin
        setpoint_next    = setpoint_reg;
        override_next    = override_reg;
        seen_minute_next = seen_minute_reg;
        heat_next        = heat_reg;
        cool_next        = cool_reg;
        if (!in_func_reg) begin
            // tick: hysteresis on the setpoint as it stands
            if (temp_ext < band_lo) begin
                heat_next = 1'b1;
                cool_next = 1'b0;
            end else if (temp_ext > band_hi) begin
                heat_next = 1'b0;
                cool_next = 1'b1;
            end
            // schedule once per new minute
            if (minute != seen_minute_reg) begin
                seen_minute_next = minute;
                if (cfg.sched_on && sched.found) begin
                    if (!override_reg) begin
                        setpoint_next = sched.setpoint;
                        override_next = 1'b0;
                    end else if (setpoint_reg == sched.setpoint) begin
                        // manual value caught up with the schedule
                        override_next = 1'b0;
                    end
                end
            end
        end else begin
            // manual entry: clamp low first, high limit wins
            setpoint_next = manual_sp;
            if (setpoint_next < sht_pkg::SP_MIN) begin
                setpoint_next = sht_pkg::SP_MIN;
            end
            if (setpoint_next > sht_pkg::SP_MAX) begin
                setpoint_next = sht_pkg::SP_MAX;
            end
            override_next = 1'b1;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= sht_pkg::SETPOINT_RST;
            override_reg    <= 1'b0;
            seen_minute_reg <= sht_pkg::NO_MINUTE;
            heat_reg        <= 1'b0;
            cool_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                setpoint_reg    <= setpoint_next;
                override_reg    <= override_next;
                seen_minute_reg <= seen_minute_next;
                heat_reg        <= heat_next;
                cool_reg        <= cool_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0, override_next, setpoint_next, cool_next, heat_next};
        end
    end

    // relays are never both on
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(heat_reg && cool_reg))
        else $error("heat and cool relays both on");

    // a manual word sets the override and leaves the relays alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_func_reg) |=> (override_reg && $stable(heat_reg) && $stable(cool_reg)))
        else $error("manual word did not set override or moved relays");

    // a manual setpoint lands at or below the upper clamp limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_func_reg) |=> (setpoint_reg <= sht_pkg::SP_MAX))
        else $error("manual setpoint above upper limit");

    // every processed word yields a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed word without result");

    // the output word's relay and override bits mirror the state they were built from
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_tdata[0] == heat_reg && m_tdata[1] == cool_reg &&
                  m_tdata[14] == override_reg))
        else $error("result word differs from state");

endmodule
